// ----- hw/rtl/swsc_pkg.sv -----
// Package for the swirl warp source coordinate block: widths, constants, types, helpers.
package swsc_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 8;
	localparam int GUARD      = 8;
	localparam int RAD_BITS   = 12;
	localparam int TWIST_BITS = 16;
	localparam int CORDIC_N   = 16;

	localparam int POS_BITS = COORD_BITS + FRAC_BITS;
	localparam int OUT_BITS = POS_BITS + 2;
	localparam int CFG_W    = (POS_BITS > TWIST_BITS) ? POS_BITS : TWIST_BITS;
	localparam int FG       = FRAC_BITS + GUARD;
	localparam int CW       = RAD_BITS + FG + 3;
	localparam int ZW       = 20;
	localparam int BW       = 23;
	localparam int MAG_W    = RAD_BITS + FG + 1;
	localparam int QB       = 17;
	localparam int DSH_L    = (FG < 16) ? 16 - FG : 0;
	localparam int DSH_R    = (FG >= 16) ? FG - 16 : 0;
	localparam int DW       = MAG_W + DSH_L;
	localparam int MPW      = CW + 17;
	localparam int PW       = 2 * QB;
	localparam int RPW      = QB + RAD_BITS;
	localparam int TWW      = TWIST_BITS + QB + 1;
	localparam int AW       = MAG_W + 16;
	localparam int SQW      = 2 * (POS_BITS + 1) + 1;

	localparam logic [QB-1:0] Q16_ONE = QB'(65536);
	localparam logic signed [BW-1:0] PI_Q      = BW'(205887);
	localparam logic signed [BW-1:0] TWO_PI_Q  = BW'(411775);
	localparam logic signed [BW-1:0] HALF_PI_B = BW'(102944);
	localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(102944);
	localparam logic [15:0] INV_GAIN_Q = 16'd39797;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_RADIUS   = 2'd2,
		REG_TWIST    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [POS_BITS-1:0] px;
		logic [POS_BITS-1:0] py;
		logic                warp;
	} side_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [BW-1:0] b;
	} rot_t;

	typedef struct packed {
		logic [RAD_BITS-1:0] rem;
		logic [QB-1:0]       lo;
		logic [QB-1:0]       q;
		logic                ovf;
	} div_t;

	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = ZW'(51472);
			1: r = ZW'(30386);
			2: r = ZW'(16055);
			3: r = ZW'(8150);
			4: r = ZW'(4091);
			5: r = ZW'(2047);
			6: r = ZW'(1024);
			7: r = ZW'(512);
			8: r = ZW'(256);
			9: r = ZW'(128);
			10: r = ZW'(64);
			11: r = ZW'(32);
			12: r = ZW'(16);
			13: r = ZW'(8);
			14: r = ZW'(4);
			15: r = ZW'(2);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [OUT_BITS-1:0] clamp_out(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] hi;
		logic signed [CW-1:0] lo;
		hi = CW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
		lo = -hi - CW'(1);
		if (v > hi) return hi[OUT_BITS-1:0];
		if (v < lo) return lo[OUT_BITS-1:0];
		return v[OUT_BITS-1:0];
	endfunction

endpackage

// ----- hw/rtl/swirl_warp_source_coordinate.sv -----
// Swirl warp source coordinate generator: fully pipelined CORDIC datapath.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid/in_ready, pixel_x, pixel_y   | in
//  output  | out_valid/out_ready, source_x/y, ins. | out
//  config  | cfg_valid/cfg_ready, cfg_index, data  | in
//
// One word per clock while the output is not stalled; 3 front stages, 16 vectoring CORDIC
// stages, 20 stages of magnitude scaling and one-bit-per-stage restoring division,
// 7 polynomial and angle stages, 17 rotation stages, output register.
// Reset clears the configuration to its defaults and all valid bits.
// A stall at the output freezes the whole pipeline; in_ready follows it.
module swirl_warp_source_coordinate import swsc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [COORD_BITS-1:0]      pixel_x,
	input  logic [COORD_BITS-1:0]      pixel_y,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [OUT_BITS-1:0] source_x,
	output logic signed [OUT_BITS-1:0] source_y,
	output logic                       inside_res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	logic [POS_BITS-1:0]          center_x_q, center_y_q;
	logic [RAD_BITS-1:0]          radius_q;
	logic signed [TWIST_BITS-1:0] twist_q;

	logic adv;
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= RAD_BITS'(1);
			twist_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_CENTER_X: center_x_q <= cfg_data[POS_BITS-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[POS_BITS-1:0];
				REG_RADIUS:   radius_q   <= cfg_data[RAD_BITS-1:0];
				REG_TWIST:    twist_q    <= cfg_data[TWIST_BITS-1:0];
			endcase
		end
	end

	// valid bits
	logic               v_s1, v_s2;
	logic [CORDIC_N:0]  vv_s;
	logic               v_m1, v_m2;
	logic [QB:0]        dv_s;
	logic               v_u, v_p1, v_p2, v_p3, v_p4, v_p5, v_p6;
	logic [CORDIC_N:0]  rv_s;

	// front
	logic [POS_BITS-1:0]        px_s1, py_s1, px_s2, py_s2;
	logic signed [POS_BITS:0]   dx_s1, dy_s1, dx_s2, dy_s2;
	logic [SQW-1:0]             dx2_s2, dy2_s2, kq2_s2;
	logic                       box_s2;
	logic [POS_BITS:0]          adx, ady;
	logic [RAD_BITS+FRAC_BITS-1:0] kq;

	// vectoring
	vec_t  vec_s [0:CORDIC_N];
	side_t vside_s [0:CORDIC_N];
	vec_t  vec_n [0:CORDIC_N];
	logic signed [CW-1:0] x0, y0, vxs, vys;

	// magnitude and division
	logic signed [MPW-1:0] mprod_m1, mr;
	logic signed [ZW-1:0]  z_m1, z_m2;
	side_t                 side_m1, side_m2;
	logic [DW-1:0]         dvd_m2;
	logic [MAG_W-1:0]      mag;
	div_t                  div_s [0:QB];
	div_t                  div_n [0:QB];
	logic signed [ZW-1:0]  dz_s [0:QB];
	side_t                 dside_s [0:QB];
	logic [RAD_BITS:0]     trial;

	// polynomials and angle
	logic [QB-1:0]         u_u, t_u, u_p1, t_p1, uu_p2, tt_p2;
	logic [QB-1:0]         uu_r, tt_r, uuu_r, ttt_r, s_p3, g_p3;
	logic [PW-1:0]         uu_p1, tt_p1, uuu_p2, ttt_p2;
	logic [QB+1:0]         s_w, g_w;
	logic signed [ZW-1:0]  z_u, z_p1, z_p2, z_p3, z_p4;
	side_t                 side_u, side_p1, side_p2, side_p3, side_p4, side_p5, side_p6;
	logic signed [TWW-1:0] tw_p4;
	logic [RPW-1:0]        rrp_p4;
	logic signed [BW-1:0]  tw, beta_n, beta_p5, beta_p6, beta_f;
	logic [MAG_W-1:0]      rr, a_p6;
	logic [RPW+FG:0]       rr_w;
	logic [AW-1:0]         arw_p5;

	// rotation
	rot_t  rot_s [0:CORDIC_N];
	side_t rside_s [0:CORDIC_N];
	rot_t  rot_n [0:CORDIC_N];
	logic signed [CW-1:0] rxs, rys, a_ext;

	// output
	logic signed [CW-1:0] fx, fy;

	always_comb begin
		adx = dx_s1[POS_BITS] ? (POS_BITS+1)'(-dx_s1) : dx_s1;
		ady = dy_s1[POS_BITS] ? (POS_BITS+1)'(-dy_s1) : dy_s1;
		kq  = {radius_q, {FRAC_BITS{1'b0}}};

		x0 = CW'(dx_s2) <<< GUARD;
		y0 = CW'(dy_s2) <<< GUARD;
		vec_n[0].x = x0;
		vec_n[0].y = y0;
		vec_n[0].z = '0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				vec_n[0].x = y0;
				vec_n[0].y = -x0;
				vec_n[0].z = HALF_PI_Z;
			end else begin
				vec_n[0].x = -y0;
				vec_n[0].y = x0;
				vec_n[0].z = -HALF_PI_Z;
			end
		end

		vxs = '0;
		vys = '0;
		for (int k = 1; k <= CORDIC_N; k++) begin
			vxs = vec_s[k-1].x >>> (k - 1);
			vys = vec_s[k-1].y >>> (k - 1);
			if (vec_s[k-1].y > 0) begin
				vec_n[k].x = vec_s[k-1].x + vys;
				vec_n[k].y = vec_s[k-1].y - vxs;
				vec_n[k].z = vec_s[k-1].z + atan_q16(k - 1);
			end else begin
				vec_n[k].x = vec_s[k-1].x - vys;
				vec_n[k].y = vec_s[k-1].y + vxs;
				vec_n[k].z = vec_s[k-1].z - atan_q16(k - 1);
			end
		end

		mr  = (mprod_m1 + MPW'(32768)) >>> 16;
		mag = (mr < 0) ? '0 : mr[MAG_W-1:0];

		div_n[0].ovf = (dvd_m2 >> QB) >= DW'(radius_q);
		div_n[0].rem = RAD_BITS'(dvd_m2 >> QB);
		div_n[0].lo  = dvd_m2[QB-1:0];
		div_n[0].q   = '0;
		trial = '0;
		for (int k = 1; k <= QB; k++) begin
			trial          = {div_s[k-1].rem, div_s[k-1].lo[QB-1]};
			div_n[k].ovf   = div_s[k-1].ovf;
			div_n[k].lo    = {div_s[k-1].lo[QB-2:0], 1'b0};
			if (trial >= {1'b0, radius_q}) begin
				div_n[k].rem = RAD_BITS'(trial - {1'b0, radius_q});
				div_n[k].q   = {div_s[k-1].q[QB-2:0], 1'b1};
			end else begin
				div_n[k].rem = trial[RAD_BITS-1:0];
				div_n[k].q   = {div_s[k-1].q[QB-2:0], 1'b0};
			end
		end

		uu_r  = QB'((uu_p1 + PW'(32768)) >> 16);
		tt_r  = QB'((tt_p1 + PW'(32768)) >> 16);
		uuu_r = QB'((uuu_p2 + PW'(32768)) >> 16);
		ttt_r = QB'((ttt_p2 + PW'(32768)) >> 16);
		s_w   = (QB+2)'(3) * (QB+2)'(tt_p2) - (QB+2)'(2) * (QB+2)'(ttt_r);
		g_w   = (QB+2)'(2) * (QB+2)'(uu_p2) - (QB+2)'(uuu_r);

		tw     = BW'((tw_p4 + TWW'(2048)) >>> 12);
		beta_n = BW'(z_p4) + tw;
		rr_w   = ({(RPW+FG+1)'(rrp_p4)} << FG) + (RPW+FG+1)'(32768);
		rr     = MAG_W'(rr_w >> 16);

		beta_f = beta_p6;
		if (beta_p6 > PI_Q) begin
			beta_f = beta_p6 - TWO_PI_Q;
		end else if (beta_p6 < -PI_Q) begin
			beta_f = beta_p6 + TWO_PI_Q;
		end
		a_ext = CW'(a_p6);
		rot_n[0].x = a_ext;
		rot_n[0].y = '0;
		rot_n[0].b = beta_f;
		if (beta_f > HALF_PI_B) begin
			rot_n[0].x = '0;
			rot_n[0].y = a_ext;
			rot_n[0].b = beta_f - HALF_PI_B;
		end else if (beta_f < -HALF_PI_B) begin
			rot_n[0].x = '0;
			rot_n[0].y = -a_ext;
			rot_n[0].b = beta_f + HALF_PI_B;
		end

		rxs = '0;
		rys = '0;
		for (int k = 1; k <= CORDIC_N; k++) begin
			rxs = rot_s[k-1].x >>> (k - 1);
			rys = rot_s[k-1].y >>> (k - 1);
			if (rot_s[k-1].b >= 0) begin
				rot_n[k].x = rot_s[k-1].x - rys;
				rot_n[k].y = rot_s[k-1].y + rxs;
				rot_n[k].b = rot_s[k-1].b - BW'(atan_q16(k - 1));
			end else begin
				rot_n[k].x = rot_s[k-1].x + rys;
				rot_n[k].y = rot_s[k-1].y - rxs;
				rot_n[k].b = rot_s[k-1].b + BW'(atan_q16(k - 1));
			end
		end

		fx = ((rot_s[CORDIC_N].x + CW'(1 << (GUARD - 1))) >>> GUARD)
			+ $signed(CW'(center_x_q));
		fy = ((rot_s[CORDIC_N].y + CW'(1 << (GUARD - 1))) >>> GUARD)
			+ $signed(CW'(center_y_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; vv_s <= '0;
			v_m1 <= 1'b0; v_m2 <= 1'b0; dv_s <= '0;
			v_u <= 1'b0; v_p1 <= 1'b0; v_p2 <= 1'b0; v_p3 <= 1'b0;
			v_p4 <= 1'b0; v_p5 <= 1'b0; v_p6 <= 1'b0;
			rv_s <= '0; out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			vv_s <= {vv_s[CORDIC_N-1:0], v_s2};
			v_m1 <= vv_s[CORDIC_N];
			v_m2 <= v_m1;
			dv_s <= {dv_s[QB-1:0], v_m2};
			v_u  <= dv_s[QB];
			v_p1 <= v_u;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
			v_p5 <= v_p4;
			v_p6 <= v_p5;
			rv_s <= {rv_s[CORDIC_N-1:0], v_p6};
			out_valid <= rv_s[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= {pixel_x, {FRAC_BITS{1'b0}}};
			py_s1 <= {pixel_y, {FRAC_BITS{1'b0}}};
			dx_s1 <= $signed({1'b0, pixel_x, {FRAC_BITS{1'b0}}}) - $signed({1'b0, center_x_q});
			dy_s1 <= $signed({1'b0, pixel_y, {FRAC_BITS{1'b0}}}) - $signed({1'b0, center_y_q});

			px_s2  <= px_s1;
			py_s2  <= py_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dx2_s2 <= SQW'(adx) * SQW'(adx);
			dy2_s2 <= SQW'(ady) * SQW'(ady);
			kq2_s2 <= SQW'(kq) * SQW'(kq);
			box_s2 <= (radius_q != '0) && (adx <= (POS_BITS+1)'(kq))
				&& (ady <= (POS_BITS+1)'(kq));

			vec_s[0]        <= vec_n[0];
			vside_s[0].px   <= px_s2;
			vside_s[0].py   <= py_s2;
			vside_s[0].warp <= box_s2 && (dx2_s2 + dy2_s2 <= kq2_s2);
			for (int k = 1; k <= CORDIC_N; k++) begin
				vec_s[k]   <= vec_n[k];
				vside_s[k] <= vside_s[k-1];
			end

			mprod_m1 <= MPW'(vec_s[CORDIC_N].x) * $signed({{(MPW-16){1'b0}}, INV_GAIN_Q});
			z_m1     <= vec_s[CORDIC_N].z;
			side_m1  <= vside_s[CORDIC_N];

			dvd_m2  <= (DW'(mag) << DSH_L) >> DSH_R;
			z_m2    <= z_m1;
			side_m2 <= side_m1;

			div_s[0]   <= div_n[0];
			dz_s[0]    <= z_m2;
			dside_s[0] <= side_m2;
			for (int k = 1; k <= QB; k++) begin
				div_s[k]   <= div_n[k];
				dz_s[k]    <= dz_s[k-1];
				dside_s[k] <= dside_s[k-1];
			end

			if (div_s[QB].ovf || (div_s[QB].q > Q16_ONE)) begin
				u_u <= Q16_ONE;
				t_u <= '0;
			end else begin
				u_u <= div_s[QB].q;
				t_u <= Q16_ONE - div_s[QB].q;
			end
			z_u    <= dz_s[QB];
			side_u <= dside_s[QB];

			uu_p1   <= PW'(u_u) * PW'(u_u);
			tt_p1   <= PW'(t_u) * PW'(t_u);
			u_p1    <= u_u;
			t_p1    <= t_u;
			z_p1    <= z_u;
			side_p1 <= side_u;

			uu_p2   <= uu_r;
			tt_p2   <= tt_r;
			uuu_p2  <= PW'(uu_r) * PW'(u_p1);
			ttt_p2  <= PW'(tt_r) * PW'(t_p1);
			z_p2    <= z_p1;
			side_p2 <= side_p1;

			s_p3    <= (s_w > (QB+2)'(Q16_ONE)) ? Q16_ONE : s_w[QB-1:0];
			g_p3    <= (g_w > (QB+2)'(Q16_ONE)) ? Q16_ONE : g_w[QB-1:0];
			z_p3    <= z_p2;
			side_p3 <= side_p2;

			tw_p4   <= TWW'(twist_q) * $signed({1'b0, s_p3});
			rrp_p4  <= RPW'(g_p3) * RPW'(radius_q);
			z_p4    <= z_p3;
			side_p4 <= side_p3;

			beta_p5 <= beta_n;
			arw_p5  <= AW'(rr) * AW'(INV_GAIN_Q);
			side_p5 <= side_p4;

			a_p6    <= MAG_W'((arw_p5 + AW'(32768)) >> 16);
			if (beta_p5 > PI_Q) begin
				beta_p6 <= beta_p5 - TWO_PI_Q;
			end else if (beta_p5 < -PI_Q) begin
				beta_p6 <= beta_p5 + TWO_PI_Q;
			end else begin
				beta_p6 <= beta_p5;
			end
			side_p6 <= side_p5;

			rot_s[0]   <= rot_n[0];
			rside_s[0] <= side_p6;
			for (int k = 1; k <= CORDIC_N; k++) begin
				rot_s[k]   <= rot_n[k];
				rside_s[k] <= rside_s[k-1];
			end

			inside_res <= rside_s[CORDIC_N].warp;
			if (rside_s[CORDIC_N].warp) begin
				source_x <= clamp_out(fx);
				source_y <= clamp_out(fy);
			end else begin
				source_x <= {2'b00, rside_s[CORDIC_N].px};
				source_y <= {2'b00, rside_s[CORDIC_N].py};
			end
		end
	end

endmodule

// ----- hw/rtl/swsc_checker.sv -----
// Port-level checker for the swirl warp source coordinate block, with its bind.
module swsc_checker import swsc_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [OUT_BITS-1:0] source_x,
	input logic signed [OUT_BITS-1:0] source_y,
	input logic                       inside_res
);

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(source_x) && $stable(source_y)
			&& $stable(inside_res))
		else $error("stalled result changed");

	// pipeline stalls only on a full output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output state");

	// pass-through words are whole pixels
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> source_x[FRAC_BITS-1:0] == '0
			&& source_y[FRAC_BITS-1:0] == '0)
		else $error("pass-through word has fraction bits");

	// pass-through words are non-negative and within pixel range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> source_x[OUT_BITS-1:POS_BITS] == '0
			&& source_y[OUT_BITS-1:POS_BITS] == '0)
		else $error("pass-through word out of pixel range");

endmodule

bind swirl_warp_source_coordinate swsc_checker u_swsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.source_x   (source_x),
	.source_y   (source_y),
	.inside_res (inside_res)
);
